@@ rtl/double_ended_queue_assert.svh @@
// ----------------------------------------------------------------------------
// double_ended_queue_assert
// assertion macros used by the deque control (deq_ctrl)
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

`ifndef ASSERT_OFF

`define DEQ_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("deque assertion failed");

`define DEQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque assertion failed");

`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`else

`define DEQ_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define DEQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// types and constants for the double-ended queue
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH_DEF  = 16;
    localparam int DATA_W_DEF = 32;
    localparam int WORD_W     = 32;
    localparam int DATA_MAX_W = 64;
    localparam int FUNC_W     = 3;
    localparam int ERR_W      = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_HEAD = 3'd0,
        FN_PUSH_TAIL = 3'd1,
        FN_POP_HEAD  = 3'd2,
        FN_POP_TAIL  = 3'd3,
        FN_PEEK_HEAD = 3'd4,
        FN_PEEK_TAIL = 3'd5,
        FN_FLUSH     = 3'd6
    } t_func;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK        = 2'd0,
        ERR_OVERFLOW  = 2'd1,
        ERR_UNDERFLOW = 2'd2
    } t_err;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_READ = 2'd1,
        ST_OUT  = 2'd2
    } t_state;

endpackage

@@ rtl/deq_ram.sv @@
// ----------------------------------------------------------------------------
// deq_ram
// entry store, one write port and one read port, registered read data
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_W_DEF,
    localparam int PTR_W     = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [PTR_W-1:0]      i_waddr,
    input  logic [DATA_WIDTH-1:0] i_wdata,
    input  logic                  i_re,
    input  logic [PTR_W-1:0]      i_raddr,
    output logic [DATA_WIDTH-1:0] o_rdata
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/deq_ctrl.sv @@
// ----------------------------------------------------------------------------
// deq_ctrl
// pointer and count keeping, store access sequencing and result register
// ----------------------------------------------------------------------------
`include "double_ended_queue_assert.svh"

module deq_ctrl #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_W_DEF,
    localparam int PTR_W     = $clog2(DEPTH),
    localparam int CNT_W     = $clog2(DEPTH + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [deq_pkg::FUNC_W-1:0]   i_func,
    input  logic [deq_pkg::WORD_W-1:0]   i_data_in,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [deq_pkg::WORD_W-1:0]   o_data_out,
    output logic                         o_data_valid,
    output logic [deq_pkg::ERR_W-1:0]    o_error,
    output logic [CNT_W-1:0]             o_count,
    output logic                         o_empty_res,
    output logic                         o_full_res,
    output logic                         o_we,
    output logic [PTR_W-1:0]             o_waddr,
    output logic [DATA_WIDTH-1:0]        o_wdata,
    output logic                         o_re,
    output logic [PTR_W-1:0]             o_raddr,
    input  logic [DATA_WIDTH-1:0]        i_rdata
);

    deq_pkg::t_state               r_state, n_state;
    logic [PTR_W-1:0]              r_head, n_head;
    logic [PTR_W-1:0]              r_tail, n_tail;
    logic [CNT_W-1:0]              r_count, n_count;
    logic [deq_pkg::WORD_W-1:0]    r_data, n_data;
    logic                          r_dvalid, n_dvalid;
    deq_pkg::t_err                 r_err, n_err;

    logic                          w_full;
    logic                          w_empty;
    logic                          w_accept;
    logic                          w_rd;
    logic [PTR_W-1:0]              w_head_fwd, w_head_back;
    logic [PTR_W-1:0]              w_tail_fwd, w_tail_back;
    logic [deq_pkg::DATA_MAX_W-1:0] w_in_ext;
    logic [deq_pkg::DATA_MAX_W-1:0] w_rd_ext;

    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_empty = (r_count == '0);

    assign w_head_fwd  = (r_head == PTR_W'(DEPTH - 1)) ? '0 : r_head + PTR_W'(1);
    assign w_head_back = (r_head == '0) ? PTR_W'(DEPTH - 1) : r_head - PTR_W'(1);
    assign w_tail_fwd  = (r_tail == PTR_W'(DEPTH - 1)) ? '0 : r_tail + PTR_W'(1);
    assign w_tail_back = (r_tail == '0) ? PTR_W'(DEPTH - 1) : r_tail - PTR_W'(1);

    assign w_in_ext = deq_pkg::DATA_MAX_W'(i_data_in);
    assign w_rd_ext = deq_pkg::DATA_MAX_W'(i_rdata);
    assign o_wdata  = w_in_ext[DATA_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= deq_pkg::ST_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data   <= n_data;
        r_dvalid <= n_dvalid;
        r_err    <= n_err;
    end

    always_comb begin
        o_stall  = !((r_state == deq_pkg::ST_IDLE) ||
                     ((r_state == deq_pkg::ST_OUT) && !i_stall));
        o_valid  = (r_state == deq_pkg::ST_OUT);
        w_accept = i_valid && !o_stall;
        w_rd     = 1'b0;
        n_state  = r_state;
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_data   = r_data;
        n_dvalid = r_dvalid;
        n_err    = r_err;
        o_we     = 1'b0;
        o_waddr  = r_tail;
        o_re     = 1'b0;
        o_raddr  = r_head;

        if (r_state == deq_pkg::ST_READ) begin
            n_data = w_rd_ext[deq_pkg::WORD_W-1:0];
        end

        if (w_accept) begin
            n_data   = '0;
            n_dvalid = 1'b0;
            n_err    = deq_pkg::ERR_OK;
            unique case (deq_pkg::t_func'(i_func))
                deq_pkg::FN_PUSH_HEAD: begin
                    if (w_full) begin
                        n_err = deq_pkg::ERR_OVERFLOW;
                    end else begin
                        o_we    = 1'b1;
                        o_waddr = w_head_back;
                        n_head  = w_head_back;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                deq_pkg::FN_PUSH_TAIL: begin
                    if (w_full) begin
                        n_err = deq_pkg::ERR_OVERFLOW;
                    end else begin
                        o_we    = 1'b1;
                        o_waddr = r_tail;
                        n_tail  = w_tail_fwd;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                deq_pkg::FN_POP_HEAD: begin
                    if (w_empty) begin
                        n_err = deq_pkg::ERR_UNDERFLOW;
                    end else begin
                        w_rd    = 1'b1;
                        o_raddr = r_head;
                        n_head  = w_head_fwd;
                        n_count = r_count - CNT_W'(1);
                    end
                end
                deq_pkg::FN_POP_TAIL: begin
                    if (w_empty) begin
                        n_err = deq_pkg::ERR_UNDERFLOW;
                    end else begin
                        w_rd    = 1'b1;
                        o_raddr = w_tail_back;
                        n_tail  = w_tail_back;
                        n_count = r_count - CNT_W'(1);
                    end
                end
                deq_pkg::FN_PEEK_HEAD: begin
                    if (w_empty) begin
                        n_err = deq_pkg::ERR_UNDERFLOW;
                    end else begin
                        w_rd    = 1'b1;
                        o_raddr = r_head;
                    end
                end
                deq_pkg::FN_PEEK_TAIL: begin
                    if (w_empty) begin
                        n_err = deq_pkg::ERR_UNDERFLOW;
                    end else begin
                        w_rd    = 1'b1;
                        o_raddr = w_tail_back;
                    end
                end
                deq_pkg::FN_FLUSH: begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_count = '0;
                end
                default: begin
                end
            endcase
            o_re     = w_rd;
            n_dvalid = w_rd;
        end

        unique case (r_state)
            deq_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_rd ? deq_pkg::ST_READ : deq_pkg::ST_OUT;
                end
            end
            deq_pkg::ST_READ: begin
                n_state = deq_pkg::ST_OUT;
            end
            deq_pkg::ST_OUT: begin
                if (w_accept) begin
                    n_state = w_rd ? deq_pkg::ST_READ : deq_pkg::ST_OUT;
                end else if (!i_stall) begin
                    n_state = deq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = deq_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_data_out   = r_data;
    assign o_data_valid = r_dvalid;
    assign o_error      = r_err;
    assign o_count      = r_count;
    assign o_empty_res  = w_empty;
    assign o_full_res   = w_full;

    `DEQ_ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH))
    `DEQ_ASSERT_ALWAYS(a_one_access, i_clk, i_rst_n, !(o_we && o_re))
    `DEQ_ASSERT_IMPLY(a_read_blocks, i_clk, i_rst_n, r_state == deq_pkg::ST_READ, o_stall)
    `DEQ_ASSERT_NEXT(a_read_to_out, i_clk, i_rst_n, r_state == deq_pkg::ST_READ,
        (r_state == deq_pkg::ST_OUT) && r_dvalid)

endmodule

@@ rtl/double_ended_queue.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue
// double-ended queue over a circular entry store with head and tail pointers
//
// channel | dir | handshake          | fields
// --------+-----+--------------------+--------------------------------------
// input   | in  | i_valid / o_stall  | i_func, i_data_in
// result  | out | o_valid / i_stall  | o_data_out, o_data_valid, o_error,
//         |     |                    | o_count, o_empty_res, o_full_res
//
// push, flush and failed ops: one word per cycle while the result is not stalled, result in the next cycle
// pop and peek: input is stalled while the registered read of the store is pending
// the next word is taken in the cycle the pending result leaves
// a stalled result holds, and input is stalled until it is taken
// reset clears pointers and count at once, the store is not cleared
// ----------------------------------------------------------------------------
module double_ended_queue #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_W_DEF,
    localparam int PTR_W     = $clog2(DEPTH),
    localparam int CNT_W     = $clog2(DEPTH + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [deq_pkg::FUNC_W-1:0]   i_func,
    input  logic [deq_pkg::WORD_W-1:0]   i_data_in,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [deq_pkg::WORD_W-1:0]   o_data_out,
    output logic                         o_data_valid,
    output logic [deq_pkg::ERR_W-1:0]    o_error,
    output logic [CNT_W-1:0]             o_count,
    output logic                         o_empty_res,
    output logic                         o_full_res
);

    logic                  w_we;
    logic [PTR_W-1:0]      w_waddr;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic                  w_re;
    logic [PTR_W-1:0]      w_raddr;
    logic [DATA_WIDTH-1:0] w_rdata;

    deq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_data_in    (i_data_in),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_data_out   (o_data_out),
        .o_data_valid (o_data_valid),
        .o_error      (o_error),
        .o_count      (o_count),
        .o_empty_res  (o_empty_res),
        .o_full_res   (o_full_res),
        .o_we         (w_we),
        .o_waddr      (w_waddr),
        .o_wdata      (w_wdata),
        .o_re         (w_re),
        .o_raddr      (w_raddr),
        .i_rdata      (w_rdata)
    );

    deq_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

endmodule
